// File: hdl/elsm_pkg.sv
package elsm_pkg;

    localparam int LINE_MAX_DEF = 2048;
    localparam int PIX_W = 24;
    localparam int POSOUT_W = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;
    localparam int OQ_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd2;

    localparam logic [8:0] WEIGHT_RESET = 9'd154;
    localparam logic [7:0] THRESHOLD_RESET = 8'd100;
    localparam logic [11:0] LENGTH_RESET = 12'd640;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic rd_first;
    } elsm_ctl_t;

    function automatic logic [8:0] eff_weight(input logic [8:0] w);
        logic [8:0] r;
        r = w;
        if (w < 9'd64)
        begin
            r = 9'd64;
        end
        else if (w > 9'd256)
        begin
            r = 9'd256;
        end
        return r;
    endfunction

    // Recursive step: if x, prev nonzero and |x - prev| < thr*256, state + w*(x - state)/256 rounded half up; else x.
    function automatic pix_t smooth_value(input pix_t x, input pix_t st, input pix_t prev,
                                          input logic [8:0] w, input logic [7:0] thr);
        pix_t d;
        logic signed [25:0] diff;
        logic signed [34:0] prod;
        logic signed [34:0] acc;
        pix_t y;
        d = (prev > x) ? (prev - x) : (x - prev);
        diff = $signed({2'b00, x}) - $signed({2'b00, st});
        prod = diff * $signed({1'b0, w});
        acc = $signed({3'b000, st, 8'h00}) + prod + 35'sd128;
        y = x;
        if ((x != '0) && (prev != '0) && (d < {8'h00, thr, 8'h00}))
        begin
            y = acc[31:8];
        end
        return y;
    endfunction

endpackage

// File: hdl/elsm_front.sv
module elsm_front import elsm_pkg::*; #(
    parameter int LINE_MAX = LINE_MAX_DEF,
    parameter int POSW = $clog2(LINE_MAX),
    parameter int LENW = $clog2(LINE_MAX + 1),
    parameter int AW = $clog2(2 * LINE_MAX)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  pix_t            depth_in,
    input  logic [8:0]      weight,
    input  logic [7:0]      threshold,
    input  logic [LENW-1:0] len,
    output elsm_ctl_t       ctl,
    output logic [AW-1:0]   wr_addr,
    output pix_t            wr_data,
    output logic [AW-1:0]   rd_addr,
    output logic [POSW-1:0] rd_pos
);

    pix_t            fst_reg, fst_next;
    pix_t            fprev_reg, fprev_next;
    logic [POSW-1:0] wp_reg, wp_next;
    logic            bank_reg, bank_next;
    logic            ready_reg, ready_next;
    logic [POSW-1:0] pos;
    pix_t            fwd;

    always_comb
    begin
        pos = wp_reg;
        if (32'(wp_reg) >= 32'(len))
        begin
            pos = POSW'(len - LENW'(1));
        end
        rd_pos = POSW'(len - LENW'(1)) - pos;
        fwd = (pos == '0) ? depth_in
            : smooth_value(depth_in, fst_reg, fprev_reg, weight, threshold);
        wr_data = fwd;
        wr_addr = bank_reg ? AW'(32'(pos) + LINE_MAX) : AW'(pos);
        rd_addr = bank_reg ? AW'(rd_pos) : AW'(32'(rd_pos) + LINE_MAX);
        ctl.wr_en = accept;
        ctl.rd_en = accept & ready_reg;
        ctl.rd_first = (pos == '0);

        fst_next = fst_reg;
        fprev_next = fprev_reg;
        wp_next = wp_reg;
        bank_next = bank_reg;
        ready_next = ready_reg;
        if (accept)
        begin
            fprev_next = depth_in;
            if ((pos == '0) || (depth_in != '0))
            begin
                fst_next = fwd;
            end
            if ((32'(pos) + 1) >= 32'(len))
            begin
                wp_next = '0;
                bank_next = ~bank_reg;
                ready_next = 1'b1;
            end
            else
            begin
                wp_next = pos + POSW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fst_reg <= '0;
            fprev_reg <= '0;
            wp_reg <= '0;
            bank_reg <= 1'b0;
            ready_reg <= 1'b0;
        end
        else
        begin
            fst_reg <= fst_next;
            fprev_reg <= fprev_next;
            wp_reg <= wp_next;
            bank_reg <= bank_next;
            ready_reg <= ready_next;
        end
    end

endmodule

// File: hdl/elsm_back.sv
module elsm_back import elsm_pkg::*; #(
    parameter int LINE_MAX = LINE_MAX_DEF,
    parameter int POSW = $clog2(LINE_MAX),
    parameter int AW = $clog2(2 * LINE_MAX)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  elsm_ctl_t           ctl,
    input  logic [AW-1:0]       wr_addr,
    input  pix_t                wr_data,
    input  logic [AW-1:0]       rd_addr,
    input  logic [POSW-1:0]     rd_pos,
    input  logic [8:0]          weight,
    input  logic [7:0]          threshold,
    input  logic                pop,
    output logic                full,
    output logic                empty,
    output pix_t                depth_out,
    output logic [POSOUT_W-1:0] pixel_position,
    output logic                last_of_line
);

    localparam int QW = $clog2(OQ_DEPTH);

    pix_t            mem [0:2*LINE_MAX-1];
    pix_t            rdata_reg;
    logic            v1_reg, v1_next;
    logic            first_reg;
    logic [POSW-1:0] rpos_reg;

    pix_t            bst_reg, bst_next;
    pix_t            bprev_reg, bprev_next;
    pix_t            y;

    pix_t                q_pix [0:OQ_DEPTH-1];
    logic [POSOUT_W-1:0] q_pos [0:OQ_DEPTH-1];
    logic [QW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [QW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [QW:0]         cnt_reg, cnt_next;
    logic                do_pop;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
            first_reg <= ctl.rd_first;
            rpos_reg <= rd_pos;
        end
    end

    always_comb
    begin
        y = first_reg ? rdata_reg
            : smooth_value(rdata_reg, bst_reg, bprev_reg, weight, threshold);
        bst_next = bst_reg;
        bprev_next = bprev_reg;
        if (v1_reg)
        begin
            bprev_next = rdata_reg;
            if (first_reg || (rdata_reg != '0))
            begin
                bst_next = y;
            end
        end
        v1_next = ctl.rd_en;
        do_pop = pop & ~empty;
        wr_ptr_next = v1_reg ? wr_ptr_reg + QW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QW'(1) : rd_ptr_reg;
        cnt_next = cnt_reg + (QW+1)'(v1_reg) - (QW+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            q_pix[wr_ptr_reg] <= y;
            q_pos[wr_ptr_reg] <= POSOUT_W'(rpos_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            bst_reg <= '0;
            bprev_reg <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            v1_reg <= v1_next;
            bst_reg <= bst_next;
            bprev_reg <= bprev_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    assign full = (32'(cnt_reg) + 32'(v1_reg)) >= OQ_DEPTH;
    assign empty = (cnt_reg == '0);
    assign depth_out = q_pix[rd_ptr_reg];
    assign pixel_position = q_pos[rd_ptr_reg];
    assign last_of_line = (q_pos[rd_ptr_reg] == '0);

endmodule

// File: hdl/edge_preserving_line_smoother.sv
// Edge-preserving depth line smoother. One pixel is taken per clock while full is low;
// each input pixel is filtered left to right and stored, and at the same time yields
// one pixel of the previous line filtered right to left, so results start after the
// first full line and come out in descending position. For each result the line-store
// read is registered on the input transfer, and the backward step then writes the
// result queue from that register. While full is low the sustained rate is one pixel
// per clock, set by the combinational recursive steps and the one write plus one read
// port of the two-bank line store; a four-entry result queue absorbs stalls on the
// output side. The store needs no clearing after reset. Configuration writes are
// always ready and must only be made while idle.
module edge_preserving_line_smoother import elsm_pkg::*; #(
    parameter int LINE_MAX = LINE_MAX_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [PIX_W-1:0]      depth_in,
    output logic                  empty,
    input  logic                  pop,
    output logic [PIX_W-1:0]      depth_out,
    output logic [POSOUT_W-1:0]   pixel_position,
    output logic                  last_of_line,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int POSW = $clog2(LINE_MAX);
    localparam int LENW = $clog2(LINE_MAX + 1);
    localparam int AW = $clog2(2 * LINE_MAX);

    logic [8:0]      weight_reg;
    logic [7:0]      threshold_reg;
    logic [11:0]     length_reg;
    logic [LENW-1:0] len;
    logic [8:0]      weight;
    logic            accept;
    elsm_ctl_t       ctl;
    logic [AW-1:0]   wr_addr;
    logic [AW-1:0]   rd_addr;
    pix_t            wr_data;
    logic [POSW-1:0] rd_pos;

    assign cfg_ready = 1'b1;
    assign accept = push & ~full;
    assign weight = eff_weight(weight_reg);

    always_comb
    begin
        len = LENW'(length_reg);
        if (length_reg < 12'd2)
        begin
            len = LENW'(2);
        end
        else if (32'(length_reg) > LINE_MAX)
        begin
            len = LENW'(LINE_MAX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= WEIGHT_RESET;
            threshold_reg <= THRESHOLD_RESET;
            length_reg <= LENGTH_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_WEIGHT:    weight_reg <= cfg_data[8:0];
                REG_THRESHOLD: threshold_reg <= cfg_data[7:0];
                REG_LENGTH:    length_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    elsm_front #(.LINE_MAX(LINE_MAX)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .depth_in  (depth_in),
        .weight    (weight),
        .threshold (threshold_reg),
        .len       (len),
        .ctl       (ctl),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_pos    (rd_pos)
    );

    elsm_back #(.LINE_MAX(LINE_MAX)) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .rd_addr        (rd_addr),
        .rd_pos         (rd_pos),
        .weight         (weight),
        .threshold      (threshold_reg),
        .pop            (pop),
        .full           (full),
        .empty          (empty),
        .depth_out      (depth_out),
        .pixel_position (pixel_position),
        .last_of_line   (last_of_line)
    );

endmodule

// File: hdl/elsm_checker.sv
module elsm_checker import elsm_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                push,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input logic [PIX_W-1:0]    depth_out,
    input logic [POSOUT_W-1:0] pixel_position,
    input logic                last_of_line
);

    // The end-of-line flag marks exactly the pixel at position zero.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (last_of_line == (pixel_position == '0)))
        else $error("last_of_line disagrees with pixel_position");

    // A result can only appear after an input transfer has passed the line-store read and the backward step.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(empty) |-> $past(push && !full, 2))
        else $error("result appeared without a matching input transfer");

    // A waiting result holds until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(depth_out) && $stable(pixel_position)))
        else $error("waiting result changed before transfer");

endmodule

bind edge_preserving_line_smoother elsm_checker u_elsm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .depth_out      (depth_out),
    .pixel_position (pixel_position),
    .last_of_line   (last_of_line)
);
